FILE: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the max-heap priority queue.
// No dependencies; used by max_heap_priority_queue_top and the testbench.
package mhpq_pkg;

    localparam int KEY_PORT_W = 32;
    localparam int POS_W      = 9;
    localparam int CNT_PORT_W = 9;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;
    localparam int S_PAD_W    = S_TDATA_W - KEY_PORT_W - POS_W;
    localparam int M_PAD_W    = M_TDATA_W - KEY_PORT_W - CNT_PORT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_EXTRACT  = 2'd1,
        CMD_INCREASE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_EMPTY   = 3'd1,
        STATUS_FULL    = 3'd2,
        STATUS_BAD_POS = 3'd3,
        STATUS_SMALLER = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EX_RD1,
        ST_EX_LAST,
        ST_INC_CHK,
        ST_UP_CMP,
        ST_DN_RR,
        ST_DN_CMP,
        ST_WR_V,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/mhpq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/max_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue: command sequencer, heap RAM and result register.
// Depends on mhpq_pkg and mhpq_ram.
//
// One request in, one result out. A request carries a command in s_tuser (insert,
// extract maximum, increase key at a one-based position), the key and the position
// in s_tdata. The result gives the extracted key (zero otherwise) and the count held
// after the command in m_tdata, and the status in m_tuser. Requests are taken one at
// a time: s_tready is high while the sequencer is idle, which includes the time a
// finished result still waits in the output register. The heap lives in one RAM with
// a registered read port; the key being moved is held in a register and only
// the hole is written, so each level of a sift up costs one RAM read and each level
// of a sift down two (both children through the single read port). Each command runs
// from dispatch to a done state, which waits while the output register still holds
// an untaken result, and then returns to idle for the next request. An insert writes
// straight into an empty heap, else sifts up; an increase ends at the check when the
// key is smaller or sits at the root, else sifts up; an extract reads the root, then
// the last entry, which it writes back straight when at most one key is left, else
// sifts down; an error (empty or full heap, bad position) goes straight to done.
// There is no clearing pass: entries are read only at positions 1..count, which
// have always been written.
module max_heap_priority_queue_top #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] key, [40:32] position, [47:41] zero
    input  logic [mhpq_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] cmd
    input  logic [mhpq_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] result_key, [40:32] count, [47:41] zero
    output logic [mhpq_pkg::M_TDATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [mhpq_pkg::STATUS_W-1:0]       m_tuser
);

    import mhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] p);
        logic [CW-1:0] t;
        t = p - ONE_C;
        return t[AW-1:0];
    endfunction

    // Request and working registers
    state_t                       state_reg, state_next;
    logic [CMD_W-1:0]             cmd_reg, cmd_next;
    logic signed [KEY_WIDTH-1:0]  key_in_reg, key_in_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                i_reg, i_next;
    logic signed [KEY_WIDTH-1:0]  v_reg, v_next;
    logic signed [KEY_WIDTH-1:0]  lk_reg, lk_next;
    logic                         r_ok_reg, r_ok_next;
    logic signed [KEY_WIDTH-1:0]  res_key_reg, res_key_next;
    status_t                      status_reg, status_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [KEY_PORT_W-1:0]        m_key_reg, m_key_next;
    status_t                      m_status_reg, m_status_next;
    logic [CNT_PORT_W-1:0]        m_count_reg, m_count_next;

    // Heap RAM port
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [KEY_WIDTH-1:0]         ram_wdata, ram_rdata;
    logic signed [KEY_WIDTH-1:0]  rd_key;

    // Decision terms
    logic                         accept;
    logic                         load_out;
    logic                         pos_ok;
    logic [CW-1:0]                ins_i;
    logic [CW-1:0]                parent;
    logic                         up_gt;
    logic                         dn_big_l, dn_big_r, dn_move;
    logic signed [KEY_WIDTH-1:0]  dn_bk;
    logic [CW:0]                  dn_child_w, dn_gc, dn_r, cnt_w;
    logic [CW-1:0]                dn_child;
    logic                         dn_more;
    logic                         inc_smaller;

    mhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key      = ram_rdata;
    assign accept      = s_tvalid && s_tready;
    assign load_out    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign pos_ok      = (pos_reg != '0) && (PW'(pos_reg) <= PW'(count_reg));
    assign ins_i       = count_reg + ONE_C;
    assign parent      = i_reg >> 1;
    assign up_gt       = v_reg > rd_key;
    assign inc_smaller = rd_key > key_in_reg;

    // Sift down: pick the larger child, left wins ties against the right
    assign cnt_w      = {1'b0, count_reg};
    assign dn_r       = {i_reg, 1'b1};
    assign dn_big_l   = lk_reg > v_reg;
    assign dn_bk      = dn_big_l ? lk_reg : v_reg;
    assign dn_big_r   = r_ok_reg && (rd_key > dn_bk);
    assign dn_move    = dn_big_l || dn_big_r;
    assign dn_child_w = dn_big_r ? {i_reg, 1'b1} : {i_reg, 1'b0};
    assign dn_child   = dn_child_w[CW-1:0];
    assign dn_gc      = {dn_child, 1'b0};
    assign dn_more    = dn_gc <= cnt_w;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == CAP_C || count_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_UP_CMP;
                        end
                    end
                    CMD_EXTRACT:
                    begin
                        state_next = (count_reg == '0) ? ST_DONE : ST_EX_RD1;
                    end
                    CMD_INCREASE:
                    begin
                        state_next = pos_ok ? ST_INC_CHK : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_EX_RD1:
            begin
                state_next = ST_EX_LAST;
            end
            ST_EX_LAST:
            begin
                state_next = (count_reg >= CW'(2)) ? ST_DN_RR : ST_DONE;
            end
            ST_INC_CHK:
            begin
                if (inc_smaller || i_reg == ONE_C)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (!up_gt)
                begin
                    state_next = ST_DONE;
                end
                else if (parent == ONE_C)
                begin
                    state_next = ST_WR_V;
                end
            end
            ST_DN_RR:
            begin
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (!dn_move)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = dn_more ? ST_DN_RR : ST_WR_V;
                end
            end
            ST_WR_V:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM controls and output register
    always_comb
    begin
        cmd_next      = cmd_reg;
        key_in_next   = key_in_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        v_next        = v_reg;
        lk_next       = lk_reg;
        r_ok_next     = r_ok_reg;
        res_key_next  = res_key_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_key_next    = m_key_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = v_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    key_in_next = KEY_WIDTH'($signed(s_tdata[KEY_PORT_W-1:0]));
                    pos_next    = s_tdata[KEY_PORT_W +: POS_W];
                end
            end
            ST_DISPATCH:
            begin
                res_key_next = '0;
                status_next  = STATUS_OK;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == CAP_C)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            count_next = ins_i;
                            i_next     = ins_i;
                            v_next     = key_in_reg;
                            if (count_reg == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = key_in_reg;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = addr_of(ins_i >> 1);
                            end
                        end
                    end
                    CMD_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - ONE_C;
                            ram_re     = 1'b1;
                        end
                    end
                    CMD_INCREASE:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = STATUS_BAD_POS;
                        end
                        else
                        begin
                            i_next    = CW'(pos_reg);
                            ram_re    = 1'b1;
                            ram_raddr = addr_of(CW'(pos_reg));
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EX_RD1:
            begin
                // root arrives; fetch the last entry (count already decremented)
                res_key_next = rd_key;
                ram_re       = 1'b1;
                ram_raddr    = count_reg[AW-1:0];
            end
            ST_EX_LAST:
            begin
                v_next = rd_key;
                i_next = ONE_C;
                if (count_reg >= CW'(2))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(1);
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rd_key;
                end
            end
            ST_INC_CHK:
            begin
                if (inc_smaller)
                begin
                    status_next = STATUS_SMALLER;
                end
                else
                begin
                    v_next = key_in_reg;
                    if (i_reg == ONE_C)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = key_in_reg;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(parent);
                    end
                end
            end
            ST_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(i_reg);
                if (up_gt)
                begin
                    // pull the parent down into the hole, climb one level
                    ram_wdata = rd_key;
                    i_next    = parent;
                    if (parent != ONE_C)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(parent >> 1);
                    end
                end
                else
                begin
                    ram_wdata = v_reg;
                end
            end
            ST_DN_RR:
            begin
                lk_next   = rd_key;
                r_ok_next = dn_r <= cnt_w;
                if (dn_r <= cnt_w)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_of(dn_r[CW-1:0]);
                end
            end
            ST_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(i_reg);
                if (dn_move)
                begin
                    // lift the larger child into the hole, descend
                    ram_wdata = dn_big_r ? rd_key : lk_reg;
                    i_next    = dn_child;
                    if (dn_more)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = addr_of(dn_gc[CW-1:0]);
                    end
                end
                else
                begin
                    ram_wdata = v_reg;
                end
            end
            ST_WR_V:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(i_reg);
                ram_wdata = v_reg;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    m_valid_next  = 1'b1;
                    m_key_next    = KEY_PORT_W'(res_key_reg);
                    m_status_next = status_reg;
                    m_count_next  = CNT_PORT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_in_reg   <= key_in_next;
        pos_reg      <= pos_next;
        i_reg        <= i_next;
        v_reg        <= v_next;
        lk_reg       <= lk_next;
        r_ok_reg     <= r_ok_next;
        res_key_reg  <= res_key_next;
        status_reg   <= status_next;
        m_key_reg    <= m_key_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_key_reg};
    assign m_tuser  = m_status_reg;

    // Checks on the sequencer
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("heap count above capacity");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPATCH && cmd_reg == CMD_INSERT && count_reg == CAP_C)
        |-> !ram_we)
        else $error("insert into full heap wrote the RAM");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_CMP) |-> (i_reg > ONE_C))
        else $error("sift up compared at the root");

    a_dn_child_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_CMP) |-> ({i_reg, 1'b0} <= cnt_w))
        else $error("sift down read a child beyond the count");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule

FILE: test/max_heap_priority_queue_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the max-heap priority queue: watches both stream channels, predicts
// each result and compares it. Depends on mhpq_pkg.
module max_heap_priority_queue_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mhpq_pkg::CMD_W-1:0]         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [mhpq_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [mhpq_pkg::STATUS_W-1:0]      m_tuser,
    output int                                 failures,
    output int                                 pending
);

    import mhpq_pkg::*;

    typedef struct packed {
        logic [KEY_PORT_W-1:0] key;
        status_t               status;
        logic [CNT_PORT_W-1:0] count;
    } heap_result_t;

    // Shadow heap, one-based like the block
    logic signed [KEY_PORT_W-1:0] keys [1:CAPACITY];
    int                           held;
    heap_result_t                 expected_q [$];

    function automatic void swap_keys(int a, int b);
        logic signed [KEY_PORT_W-1:0] t;
        t       = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    function automatic void sift_up(int i);
        while (i > 1 && keys[i] > keys[i / 2])
        begin
            swap_keys(i, i / 2);
            i = i / 2;
        end
    endfunction

    function automatic void sift_down(int i);
        int l;
        int r;
        int big;
        forever
        begin
            l   = 2 * i;
            r   = 2 * i + 1;
            big = i;
            if (l <= held && keys[l] > keys[big])
                big = l;
            if (r <= held && keys[r] > keys[big])
                big = r;
            if (big == i)
                return;
            swap_keys(i, big);
            i = big;
        end
    endfunction

    function automatic heap_result_t apply_request(logic [CMD_W-1:0] op,
                                                   logic signed [KEY_PORT_W-1:0] k,
                                                   logic [POS_W-1:0] p);
        heap_result_t res;
        res.key    = '0;
        res.status = STATUS_OK;
        case (op)
            CMD_INSERT:
                if (held >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                begin
                    held++;
                    keys[held] = k;
                    sift_up(held);
                end
            CMD_EXTRACT:
                if (held == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.key = keys[1];
                    keys[1] = keys[held];
                    held--;
                    sift_down(1);
                end
            CMD_INCREASE:
                if (p == 0 || p > held)
                    res.status = STATUS_BAD_POS;
                else if (keys[p] > k)
                    res.status = STATUS_SMALLER;
                else
                begin
                    keys[p] = k;
                    sift_up(p);
                end
            default: ;  // unused code: no change, plain ok
        endcase
        res.count = CNT_PORT_W'(held);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        heap_result_t got;
        heap_result_t want;
        if (!rst_n)
        begin
            held     = 0;
            failures = 0;
            expected_q.delete();
        end
        else
        begin
            // Predict first so a same-edge result still finds its expectation
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tuser, s_tdata[KEY_PORT_W-1:0],
                                                   s_tdata[KEY_PORT_W +: POS_W]));
            if (m_tvalid && m_tready)
            begin
                got.key    = m_tdata[KEY_PORT_W-1:0];
                got.count  = m_tdata[KEY_PORT_W +: CNT_PORT_W];
                got.status = status_t'(m_tuser);
                if (expected_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result: key %0d status %0d count %0d",
                             $time, $signed(got.key), got.status, got.count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        $display("%0t: mismatch: expected key %0d status %0d count %0d,",
                                 $time, $signed(want.key), want.status, want.count,
                                 " got key %0d status %0d count %0d",
                                 $signed(got.key), got.status, got.count);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: test/max_heap_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the max-heap priority queue.
// Depends on mhpq_pkg, max_heap_priority_queue_top and max_heap_priority_queue_checker.
module max_heap_priority_queue_top_tb;

    import mhpq_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CAPACITY    = 256;
    localparam int SETTLE      = 40;          // cycles to watch after the last result
    localparam int LIMIT_NS    = 6_000_000;   // far beyond the slowest correct run

    // Code three has no enum member; the block must ignore it
    localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [KEY_PORT_W-1:0] KEY_MIN    = 32'h8000_0000;
    localparam logic [KEY_PORT_W-1:0] KEY_MAX    = 32'h7FFF_FFFF;

    typedef enum { PHASE_FILL, PHASE_DRAIN, PHASE_MIXED } phase_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] key, [40:32] position, [47:41] zero
    logic [CMD_W-1:0]     s_tuser  = '0;   // [1:0] cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] result_key, [40:32] count, [47:41] zero
    logic [STATUS_W-1:0]  m_tuser;         // [2:0] status

    logic quiet = 1'b0;     // high: neither side idles
    int   failures;
    int   pending;

    max_heap_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    max_heap_priority_queue_checker #(
        .CAPACITY (CAPACITY)
    ) heap_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: stall about a quarter of the time, never during a quiet stretch
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(99) >= 25);

    // Offer one request and hold it until the block takes it. Leave tvalid high
    // afterward; drop it only when taking an idle gap so it never toggles within
    // one time step.
    task automatic send_request(logic [CMD_W-1:0] op, logic [KEY_PORT_W-1:0] k,
                                logic [POS_W-1:0] p);
        if (!quiet && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD_W{1'b0}}, p, k};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Mix extremes, a narrow band around zero (equal keys, ties in the sift) and
    // the full range
    function automatic logic [KEY_PORT_W-1:0] random_key();
        case ($urandom_range(9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return $urandom_range(1) ? '0 : '1;
            3, 4, 5: return $urandom_range(80) - 40;
            default: return $urandom();
        endcase
    endfunction

    // Mostly positions within capacity, some near the root, some anywhere in 0..511
    function automatic logic [POS_W-1:0] random_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return POS_W'($urandom_range(1, CAPACITY));
        else if (roll < 85)
            return POS_W'($urandom_range(1, 16));
        else
            return POS_W'($urandom_range(0, 511));
    endfunction

    // Bias the operation so the heap climbs to full, drains to empty or churns
    function automatic logic [CMD_W-1:0] random_op(phase_t ph);
        int roll;
        int ins_pct;
        int ext_pct;
        roll    = $urandom_range(99);
        ins_pct = (ph == PHASE_FILL) ? 75 : (ph == PHASE_DRAIN) ? 10 : 35;
        ext_pct = (ph == PHASE_FILL) ? 10 : (ph == PHASE_DRAIN) ? 75 : 35;
        if (roll < ins_pct)
            return CMD_INSERT;
        else if (roll < ins_pct + ext_pct)
            return CMD_EXTRACT;
        else if (roll < 98)
            return CMD_INCREASE;
        else
            return CMD_UNUSED;
    endfunction

    initial
    begin
        // The first fill phase overshoots capacity to hit the full case; the first drain
        // overshoots empty. The quiet churn phase gives a long stretch without idling.
        phase_t plan_kind [6];
        int     plan_len  [6];
        plan_kind = '{PHASE_FILL, PHASE_MIXED, PHASE_DRAIN, PHASE_MIXED, PHASE_FILL,
                      PHASE_DRAIN};
        plan_len  = '{420, 250, 420, 200, 250, 160};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: errors on an empty heap
        send_request(CMD_EXTRACT, random_key(), 9'd1);
        send_request(CMD_INCREASE, KEY_MAX, 9'd1);

        // Directed: key extremes, then small values
        send_request(CMD_INSERT, KEY_MIN, 9'd0);
        send_request(CMD_INSERT, KEY_MAX, 9'd0);
        send_request(CMD_INSERT, 32'h0, 9'd0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 9'd0);
        send_request(CMD_INSERT, 32'h1, 9'd0);

        // Directed: the unused code is ignored
        send_request(CMD_UNUSED, $urandom(), POS_W'($urandom_range(0, 511)));

        // Directed: bad positions (zero, one past count, all ones)
        send_request(CMD_INCREASE, KEY_MAX, 9'd0);
        send_request(CMD_INCREASE, KEY_MAX, 9'd6);
        send_request(CMD_INCREASE, KEY_MAX, 9'h1FF);

        // Directed: smaller key at the root, equal key at the root, then raise
        // the last entry so it climbs to just below the root
        send_request(CMD_INCREASE, KEY_MIN, 9'd1);
        send_request(CMD_INCREASE, KEY_MAX, 9'd1);
        send_request(CMD_INCREASE, KEY_MAX - 1, 9'd5);

        // Directed: drain completely, then extract once more on empty
        repeat (6) send_request(CMD_EXTRACT, random_key(), 9'd0);

        // Random phases
        foreach (plan_kind[ph])
        begin
            quiet <= (ph == 3);
            repeat (plan_len[ph])
                send_request(random_op(plan_kind[ph]), random_key(), random_position());
        end

        // Release the channel, wait out every outstanding result, then settle
        s_tvalid <= 1'b0;
        quiet    <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
